// File: hdl/rnmc_pkg.sv
package rnmc_pkg;

  // frame parser phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SRC,
    PH_LEN,
    PH_FWD,
    PH_OWN
  } phase_e;

  // frame error codes reported on the aborting tick
  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_HEADER,
    ERR_FWD,
    ERR_OWN
  } frame_err_e;

  // input item kinds
  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_BUTTON = 2'd2;

  // configuration register indexes
  localparam logic [7:0] CFG_NODE_ADDR   = 8'd0;
  localparam logic [7:0] CFG_MASTER_ADDR = 8'd1;
  localparam logic [7:0] CFG_TIMEOUT     = 8'd2;
  localparam logic [7:0] CFG_PWM_PERIOD  = 8'd3;

  // command bytes
  localparam logic [7:0] CMD_ACK   = 8'h41;
  localparam logic [7:0] CMD_MOTOR = 8'h4D;

  // highest amplitude or frequency level
  localparam logic [2:0] LEVEL_MAX = 3'd4;

endpackage

// File: hdl/ring_node_motor_command.sv
// ring node with motor command decoding
//
// input channel (in_valid_i / in_stall_o) carries one item per handshake:
// a received ring byte, a millisecond tick or a button sample, chosen by mode_i.
// output channel (out_valid_o / out_stall_i) returns one to four result items
// per input item, the final one flagged by last_o. forwarded headers and the
// acknowledge frame leave as several items, one ring byte each.
// configuration (cfg_valid_i / cfg_ready_o) is always ready and writes node
// address, master address, byte timeout and pwm period by index; write only
// while no item is in flight.
// an item is registered in the input register, decoded combinationally from
// there and its first result is registered in the result register.
// throughput: one item per cycle when it gives a single result and the
// receiver does not stall; an item with n result items holds the single
// result register until its last one is taken, as that register drains one
// item per cycle while the receiver does not stall.
// reset: parser idle, levels at 4, node address 3, master address 0, timeout 20
// ticks, period 100000. while the receiver stalls, the held result stays put,
// one further item waits in the input register and then in_stall_o rises.
module ring_node_motor_command #(
  parameter int PAYLOAD_MAX = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [3:0]  buttons_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [2:0]  amp_level_o,
  output logic [2:0]  freq_level_o,
  output logic [19:0] amp_compare_o,
  output logic [19:0] freq_compare_o,
  output logic [1:0]  frame_error_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);
  import rnmc_pkg::*;

  localparam logic [7:0] PayMax = 8'(PAYLOAD_MAX);

  // configuration registers
  logic [7:0]  node_addr_q, master_addr_q, timeout_q;
  logic [19:0] period_q;

  // input register
  logic       in_valid_q, in_valid_d;
  logic [1:0] mode_q;
  logic [7:0] rx_byte_q;
  logic [3:0] buttons_q;

  // parser and level state
  phase_e     phase_q, phase_d;
  logic [7:0] dest_q, dest_d, src_q, src_d, len_q, len_d;
  logic [7:0] idx_q, idx_d, wait_q, wait_d;
  // only the first three payload bytes are ever looked at
  logic [7:0] pay_q [3];
  logic [7:0] pay_d [3];
  logic [2:0] amp_q, amp_d, freq_q, freq_d;
  logic [3:0] prev_q, prev_d;

  // result register, drained one item per cycle while the receiver does not stall
  logic       res_valid_q, res_valid_d;
  logic [7:0] res_byte_q [4];
  logic [7:0] res_byte_d [4];
  logic [1:0] res_cnt_q, res_cnt_d, res_pos_q, res_pos_d;
  logic       res_txv_q, res_txv_d;
  logic [1:0] res_err_q, res_err_d;
  logic [2:0] res_amp_q, res_freq_q;

  logic       advance, accept, res_done;
  logic [2:0] ntx;
  logic       finish;
  frame_err_e err;
  logic [3:0] rise;
  logic [2:0] amp_mid, freq_mid;

  // current result is the last of its group and is being taken
  assign res_done   = res_valid_q && (res_pos_q == res_cnt_q) && !out_stall_i;
  assign advance    = in_valid_q && (!res_valid_q || res_done);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // one step of the node for the registered item
  always_comb begin
    phase_d  = phase_q;
    dest_d   = dest_q;
    src_d    = src_q;
    len_d    = len_q;
    idx_d    = idx_q;
    wait_d   = wait_q;
    pay_d    = pay_q;
    amp_d    = amp_q;
    freq_d   = freq_q;
    prev_d   = prev_q;
    res_byte_d = '{default: 8'h00};
    ntx      = 3'd0;
    finish   = 1'b0;
    err      = ERR_NONE;
    rise     = buttons_q & ~prev_q;
    amp_mid  = amp_q;
    freq_mid = freq_q;

    case (mode_q)
      MODE_BYTE: begin
        wait_d = 8'h00;
        case (phase_q)
          PH_IDLE: begin
            dest_d  = rx_byte_q;
            phase_d = PH_SRC;
          end
          PH_SRC: begin
            src_d   = rx_byte_q;
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            idx_d = 8'h00;
            if (dest_q != node_addr_q) begin
              // foreign frame: header leaves now
              len_d         = rx_byte_q;
              res_byte_d[0] = dest_q;
              res_byte_d[1] = src_q;
              res_byte_d[2] = rx_byte_q;
              ntx           = 3'd3;
              phase_d       = (rx_byte_q == 8'h00) ? PH_IDLE : PH_FWD;
            end else begin
              len_d = (rx_byte_q > PayMax) ? PayMax : rx_byte_q;
              if (len_d == 8'h00) begin
                phase_d = PH_IDLE;
                finish  = 1'b1;
              end else begin
                phase_d = PH_OWN;
              end
            end
          end
          PH_FWD: begin
            res_byte_d[0] = rx_byte_q;
            ntx           = 3'd1;
            idx_d         = idx_q + 8'd1;
            if (idx_d >= len_q) phase_d = PH_IDLE;
          end
          PH_OWN: begin
            case (idx_q)
              8'd0:    pay_d[0] = rx_byte_q;
              8'd1:    pay_d[1] = rx_byte_q;
              8'd2:    pay_d[2] = rx_byte_q;
              default: ;
            endcase
            idx_d = idx_q + 8'd1;
            if (idx_d >= len_q) begin
              phase_d = PH_IDLE;
              finish  = 1'b1;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
      MODE_TICK: begin
        if (phase_q != PH_IDLE) begin
          wait_d = wait_q + 8'd1;
          if (wait_d >= timeout_q) begin
            case (phase_q)
              PH_FWD:  err = ERR_FWD;
              PH_OWN:  err = ERR_OWN;
              default: err = ERR_HEADER;
            endcase
            phase_d = PH_IDLE;
            wait_d  = 8'h00;
            idx_d   = 8'h00;
          end
        end
      end
      MODE_BUTTON: begin
        // down first, then up, within each pair
        if (rise[0] && amp_q != 3'd0) amp_mid = amp_q - 3'd1;
        amp_d = (rise[1] && amp_mid < LEVEL_MAX) ? amp_mid + 3'd1 : amp_mid;
        if (rise[2] && freq_q != 3'd0) freq_mid = freq_q - 3'd1;
        freq_d = (rise[3] && freq_mid < LEVEL_MAX) ? freq_mid + 3'd1 : freq_mid;
        prev_d = buttons_q;
      end
      default: ;
    endcase

    // completed own frame: acknowledge or motor command
    if (finish && len_d != 8'h00) begin
      if (pay_d[0] == CMD_ACK) begin
        res_byte_d[0] = master_addr_q;
        res_byte_d[1] = node_addr_q;
        res_byte_d[2] = 8'd1;
        res_byte_d[3] = CMD_ACK;
        ntx           = 3'd4;
      end else if (pay_d[0] == CMD_MOTOR && len_d >= 8'd3) begin
        amp_d  = (pay_d[1] > {5'b0, LEVEL_MAX}) ? LEVEL_MAX : pay_d[1][2:0];
        freq_d = (pay_d[2] > {5'b0, LEVEL_MAX}) ? LEVEL_MAX : pay_d[2][2:0];
      end
    end

    res_txv_d = (ntx != 3'd0);
    res_cnt_d = res_txv_d ? 2'(ntx - 3'd1) : 2'd0;
    res_err_d = err;
  end

  // result register progression
  always_comb begin
    res_valid_d = res_valid_q;
    res_pos_d   = res_pos_q;
    if (res_valid_q && !out_stall_i) begin
      if (res_pos_q == res_cnt_q) res_valid_d = 1'b0;
      else                        res_pos_d   = res_pos_q + 2'd1;
    end
    if (advance) begin
      res_valid_d = 1'b1;
      res_pos_d   = 2'd0;
    end
    in_valid_d = accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_addr_q   <= 8'd3;
      master_addr_q <= 8'd0;
      timeout_q     <= 8'd20;
      period_q      <= 20'd100000;
      in_valid_q    <= 1'b0;
      phase_q       <= PH_IDLE;
      dest_q        <= 8'h00;
      src_q         <= 8'h00;
      len_q         <= 8'h00;
      idx_q         <= 8'h00;
      wait_q        <= 8'h00;
      amp_q         <= LEVEL_MAX;
      freq_q        <= LEVEL_MAX;
      prev_q        <= 4'h0;
      res_valid_q   <= 1'b0;
      res_pos_q     <= 2'd0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_NODE_ADDR:   node_addr_q   <= cfg_data_i[7:0];
          CFG_MASTER_ADDR: master_addr_q <= cfg_data_i[7:0];
          CFG_TIMEOUT:     timeout_q     <= cfg_data_i[7:0];
          CFG_PWM_PERIOD:  period_q      <= cfg_data_i;
          default: ;
        endcase
      end
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
      res_pos_q   <= res_pos_d;
      if (advance) begin
        phase_q <= phase_d;
        dest_q  <= dest_d;
        src_q   <= src_d;
        len_q   <= len_d;
        idx_q   <= idx_d;
        wait_q  <= wait_d;
        amp_q   <= amp_d;
        freq_q  <= freq_d;
        prev_q  <= prev_d;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= mode_i;
      rx_byte_q <= rx_byte_i;
      buttons_q <= buttons_i;
    end
    if (advance) begin
      pay_q      <= pay_d;
      res_byte_q <= res_byte_d;
      res_cnt_q  <= res_cnt_d;
      res_txv_q  <= res_txv_d;
      res_err_q  <= res_err_d;
      res_amp_q  <= amp_d;
      res_freq_q <= freq_d;
    end
  end

  // pwm compare values follow the levels held with the result
  rnmc_compare u_amp_cmp (
    .level_i   (res_amp_q),
    .period_i  (period_q),
    .compare_o (amp_compare_o)
  );

  rnmc_compare u_freq_cmp (
    .level_i   (res_freq_q),
    .period_i  (period_q),
    .compare_o (freq_compare_o)
  );

  assign out_valid_o   = res_valid_q;
  assign tx_valid_o    = res_txv_q;
  assign tx_byte_o     = res_byte_q[res_pos_q];
  assign last_o        = (res_pos_q == res_cnt_q);
  assign amp_level_o   = res_amp_q;
  assign freq_level_o  = res_freq_q;
  assign frame_error_o = res_err_q;

endmodule

// File: hdl/rnmc_compare.sv
module rnmc_compare (
  input  logic [2:0]  level_i,
  input  logic [19:0] period_i,
  output logic [19:0] compare_o
);
  import rnmc_pkg::*;

  // duty/100 is k/20 with k in 1, 4, 8, 12, 16; /20 is a shift by two then /5
  // ceil(2^24 / 5), exact for dividends below 2^22
  localparam logic [21:0] RecipFive  = 22'd3355444;

  logic [23:0] scaled;
  logic [21:0] quarter;
  logic [43:0] product;

  always_comb begin
    case (level_i)
      3'd0:    scaled = {4'b0, period_i};
      3'd1:    scaled = {2'b0, period_i, 2'b0};
      3'd2:    scaled = {1'b0, period_i, 3'b0};
      3'd3:    scaled = {1'b0, period_i, 3'b0} + {2'b0, period_i, 2'b0};
      default: scaled = {period_i, 4'b0};
    endcase
  end

  assign quarter   = scaled[23:2];
  assign product   = {22'b0, quarter} * {22'b0, RecipFive};
  assign compare_o = product[43:24];

endmodule

// File: hdl/rnmc_checker.sv
module rnmc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic       tx_valid_i,
  input logic [7:0] tx_byte_i,
  input logic       last_i,
  input logic [2:0] amp_level_i,
  input logic [2:0] freq_level_i,
  input logic [1:0] frame_error_i
);
  import rnmc_pkg::*;

  // a held result keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(tx_byte_i) && $stable(last_i)
      && $stable(tx_valid_i))
    else $error("stalled result changed");

  // a step with nothing to send gives a single, empty item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !tx_valid_i |-> last_i && tx_byte_i == 8'h00)
    else $error("empty result not single");

  // levels saturate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> amp_level_i <= LEVEL_MAX && freq_level_i <= LEVEL_MAX)
    else $error("level out of range");

  // an abort comes from a tick, which never sends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_error_i != ERR_NONE |-> !tx_valid_i && last_i)
    else $error("frame error with transmit byte");

endmodule

bind ring_node_motor_command rnmc_checker u_rnmc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .tx_valid_i    (tx_valid_o),
  .tx_byte_i     (tx_byte_o),
  .last_i        (last_o),
  .amp_level_i   (amp_level_o),
  .freq_level_i  (freq_level_o),
  .frame_error_i (frame_error_o)
);
